### hw/rtl/dwtp_pkg.sv
`default_nettype none
package dwtp_pkg;

  localparam int NUM_WHEELS = 2;
  localparam int IO_WHEELS  = 2;
  localparam int ACT_WHEELS = (NUM_WHEELS < IO_WHEELS) ? NUM_WHEELS : IO_WHEELS;
  localparam int WIDX_W     = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 31;
  localparam int PER_W      = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int PQ_W       = PROD_W - FRAC_W;
  localparam int ACC_W      = 50;
  localparam int DVD_W      = DATA_W + 1 + FRAC_W;
  localparam int CNT_W      = $clog2(DVD_W);

  localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_I_RST = '0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = '0;
  localparam logic [PER_W-1:0]  PER_RST    = PER_W'(6554);
  localparam logic [GAIN_W-1:0] LIMIT_RST  = GAIN_W'(65536);

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_STEP_PERIOD  = 3'd3,
    CFG_TORQUE_LIMIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_HI) begin
      r = Q_MAX;
    end else if (x < SAT_LO) begin
      r = Q_MIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sx_data(input logic signed [DATA_W-1:0] x);
    return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  function automatic logic signed [ACC_W-1:0] sx_pq(input logic signed [PQ_W-1:0] x);
    return {{(ACC_W-PQ_W){x[PQ_W-1]}}, x};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/dwtp_div.sv
`default_nettype none
module dwtp_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  dwtp_pkg::div_req_t  req,
  output dwtp_pkg::div_rsp_t  rsp
);
  import dwtp_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PER_W-1:0] rem_r;
  logic [PER_W-1:0] dsr_r;
  logic [DVD_W-1:0] qd_r;

  logic [PER_W:0]   rem_sh;
  logic [PER_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, qd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  assign rsp.done     = done_r;
  assign rsp.quotient = qd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dsr_r <= req.divisor;
      qd_r  <= req.dividend;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];
      qd_r  <= {qd_r[DVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/dwtp_mul.sv
`default_nettype none
module dwtp_mul (
  input  wire                                      clk,
  input  wire signed [dwtp_pkg::DATA_W-1:0]        op_a,
  input  wire        [dwtp_pkg::GAIN_W-1:0]        op_b,
  output logic signed [dwtp_pkg::PROD_W-1:0]       prod_r
);
  import dwtp_pkg::*;

  logic signed [DATA_W-1:0] b_s;

  assign b_s = $signed({1'b0, op_b});

  always_ff @(posedge clk) begin
    prod_r <= op_a * b_s;
  end

endmodule
`default_nettype wire

### hw/rtl/dual_wheel_torque_pid_top.sv
// Dual-wheel torque PID controller with output clamp.
//
// Input channel (in_valid/in_ready) takes one item of two signed Q16.16
// target torques. Result channel (out_valid/out_ready) returns one item of
// the two new clamped applied torques. The user must write gains, step period
// and torque limit through cfg_we/cfg_index/cfg_wdata only while the block is
// idle; the block itself does not enforce this.
// The wheels are processed one after another by a sequencer around one
// shared 32x32 multiplier and one radix-2 divider. When step_period is
// nonzero the divider sets the time per wheel, beside the error, multiply
// and clamp steps; when it is zero the divide is skipped. in_ready is low
// while a wheel is in work, so one item is finished before the next is
// accepted.
//
// The result sits in an output register; the next item can be accepted
// while it waits. A stalled receiver only holds the block at the end of the
// following item. Reset clears the per-wheel torque, error and integral to
// zero and loads the default configuration.
`default_nettype none
module dual_wheel_torque_pid_top (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire signed [dwtp_pkg::DATA_W-1:0]      in_target_left,
  input  wire signed [dwtp_pkg::DATA_W-1:0]      in_target_right,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [dwtp_pkg::DATA_W-1:0]     out_torque_left,
  output logic signed [dwtp_pkg::DATA_W-1:0]     out_torque_right,
  input  wire                                    cfg_we,
  input  wire        [dwtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire        [dwtp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dwtp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_M0, ST_M1, ST_M2, ST_M3, ST_WDIV, ST_M4, ST_M5,
    ST_CLAMP, ST_DONE
  } state_t;

  localparam logic [WIDX_W-1:0] LAST_WHEEL = WIDX_W'(ACT_WHEELS - 1);

  state_t                    state_r;
  logic [WIDX_W-1:0]         wheel_r;

  logic [GAIN_W-1:0]         gain_p_r;
  logic [GAIN_W-1:0]         gain_i_r;
  logic [GAIN_W-1:0]         gain_d_r;
  logic [PER_W-1:0]          per_r;
  logic [GAIN_W-1:0]         limit_r;

  logic signed [DATA_W-1:0]  applied_r [NUM_WHEELS];
  logic signed [DATA_W-1:0]  last_r    [NUM_WHEELS];
  logic signed [DATA_W-1:0]  integ_r   [NUM_WHEELS];

  logic signed [DATA_W-1:0]  tgt_left_r;
  logic signed [DATA_W-1:0]  tgt_right_r;
  logic signed [DATA_W-1:0]  e_r;
  logic signed [DATA_W-1:0]  de_r;
  logic                      dneg_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DATA_W-1:0]  tq_left_r;
  logic signed [DATA_W-1:0]  tq_right_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_left_r;
  logic signed [DATA_W-1:0]  out_right_r;

  logic signed [DATA_W-1:0]  tgt_cur;
  logic signed [DATA_W-1:0]  app_cur;
  logic signed [DATA_W:0]    e_diff;
  logic signed [DATA_W-1:0]  e_sat;
  logic signed [DATA_W:0]    d_diff;
  logic        [DATA_W:0]    d_mag;
  logic signed [DATA_W-1:0]  mul_a;
  logic        [GAIN_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PQ_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]   integ_sum;
  logic signed [ACC_W-1:0]   lim_pos;
  logic signed [ACC_W-1:0]   lim_neg;
  logic signed [DATA_W-1:0]  t_clamp;
  logic signed [DATA_W-1:0]  de_sat;
  logic                      per_zero;
  logic                      out_free;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_torque_left  = out_left_r;
  assign out_torque_right = out_right_r;
  assign per_zero         = (per_r == '0);
  assign out_free         = !out_valid_r || out_ready;

  assign tgt_cur = (wheel_r == '0) ? tgt_left_r : tgt_right_r;
  assign app_cur = applied_r[wheel_r];
  assign e_diff  = {tgt_cur[DATA_W-1], tgt_cur} - {app_cur[DATA_W-1], app_cur};
  assign e_sat   = sat32({{(ACC_W-DATA_W-1){e_diff[DATA_W]}}, e_diff});
  assign d_diff  = {e_r[DATA_W-1], e_r} - {last_r[wheel_r][DATA_W-1], last_r[wheel_r]};
  assign d_mag   = d_diff[DATA_W] ? (DATA_W+1)'(-d_diff) : d_diff;
  assign prod_q  = prod_r[PROD_W-1:FRAC_W];
  assign integ_sum = sx_data(integ_r[wheel_r]) + sx_pq(prod_q);
  assign lim_pos = {{(ACC_W-GAIN_W){1'b0}}, limit_r};
  assign lim_neg = -lim_pos;

  always_comb begin
    if (acc_r > lim_pos) begin
      t_clamp = lim_pos[DATA_W-1:0];
    end else if (acc_r < lim_neg) begin
      t_clamp = lim_neg[DATA_W-1:0];
    end else begin
      t_clamp = acc_r[DATA_W-1:0];
    end
  end

  // truncated quotient, saturated to the signed range
  always_comb begin
    if (!dneg_r) begin
      if (div_rsp.quotient > DVD_W'(Q_MAX)) begin
        de_sat = Q_MAX;
      end else begin
        de_sat = div_rsp.quotient[DATA_W-1:0];
      end
    end else begin
      if (div_rsp.quotient > {{(DVD_W-DATA_W){1'b0}}, Q_MIN}) begin
        de_sat = Q_MIN;
      end else begin
        de_sat = -div_rsp.quotient[DATA_W-1:0];
      end
    end
  end

  always_comb begin
    mul_a = e_r;
    mul_b = '0;
    case (state_r)
      ST_M0: begin
        mul_b = {{(GAIN_W-PER_W){1'b0}}, per_r};
      end
      ST_M1: begin
        mul_b = gain_p_r;
      end
      ST_M2: begin
        mul_a = integ_r[wheel_r];
        mul_b = gain_i_r;
      end
      ST_M4: begin
        mul_a = de_r;
        mul_b = gain_d_r;
      end
      default: begin
        mul_b = '0;
      end
    endcase
  end

  assign div_req.start    = (state_r == ST_M0) && !per_zero;
  assign div_req.dividend = {d_mag, {FRAC_W{1'b0}}};
  assign div_req.divisor  = per_r;

  dwtp_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  dwtp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= GAIN_P_RST;
      gain_i_r <= GAIN_I_RST;
      gain_d_r <= GAIN_D_RST;
      per_r    <= PER_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:       gain_p_r <= cfg_wdata;
        CFG_GAIN_I:       gain_i_r <= cfg_wdata;
        CFG_GAIN_D:       gain_d_r <= cfg_wdata;
        CFG_STEP_PERIOD:  per_r    <= cfg_wdata[PER_W-1:0];
        CFG_TORQUE_LIMIT: limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wheel_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        applied_r[i] <= '0;
        last_r[i]    <= '0;
        integ_r[i]   <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            tgt_left_r  <= in_target_left;
            tgt_right_r <= in_target_right;
            tq_left_r   <= '0;
            tq_right_r  <= '0;
            wheel_r     <= '0;
            state_r     <= ST_ERR;
          end
        end
        ST_ERR: begin
          e_r     <= e_sat;
          state_r <= ST_M0;
        end
        ST_M0: begin
          dneg_r  <= d_diff[DATA_W];
          state_r <= ST_M1;
        end
        ST_M1: begin
          if (!per_zero) begin
            integ_r[wheel_r] <= sat32(integ_sum);
          end
          acc_r   <= sx_data(app_cur);
          state_r <= ST_M2;
        end
        ST_M2: begin
          acc_r   <= acc_r + sx_pq(prod_q);
          state_r <= ST_M3;
        end
        ST_M3: begin
          acc_r   <= acc_r + sx_pq(prod_q);
          state_r <= ST_WDIV;
        end
        ST_WDIV: begin
          if (per_zero) begin
            de_r    <= '0;
            state_r <= ST_M4;
          end else if (div_rsp.done) begin
            de_r    <= de_sat;
            state_r <= ST_M4;
          end
        end
        ST_M4: begin
          state_r <= ST_M5;
        end
        ST_M5: begin
          acc_r   <= acc_r + sx_pq(prod_q);
          state_r <= ST_CLAMP;
        end
        ST_CLAMP: begin
          applied_r[wheel_r] <= t_clamp;
          last_r[wheel_r]    <= e_r;
          if (wheel_r == '0) begin
            tq_left_r <= t_clamp;
          end else begin
            tq_right_r <= t_clamp;
          end
          if (wheel_r == LAST_WHEEL) begin
            state_r <= ST_DONE;
          end else begin
            wheel_r <= wheel_r + WIDX_W'(1);
            state_r <= ST_ERR;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_left_r  <= tq_left_r;
            out_right_r <= tq_right_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sim/tb_dual_wheel_torque_pid_top.sv
`timescale 1ns / 100ps

module tb_dual_wheel_torque_pid_top;
  import dwtp_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } torque_pair_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [DATA_W-1:0] in_target_left;
  logic signed [DATA_W-1:0] in_target_right;
  logic out_valid;
  logic out_ready;
  logic signed [DATA_W-1:0] out_torque_left;
  logic signed [DATA_W-1:0] out_torque_right;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // controller state and register copies
  logic signed [DATA_W-1:0] applied [NUM_WHEELS];
  logic signed [DATA_W-1:0] last_err [NUM_WHEELS];
  logic signed [DATA_W-1:0] integ [NUM_WHEELS];
  logic [GAIN_W-1:0] kp, ki, kd, limit;
  logic [PER_W-1:0] period;

  torque_pair_t torque_q[$];
  int mismatch_cnt = 0;
  int rx_hold = 0;
  bit tx_gap_en = 1'b1;
  bit rx_stall_en = 1'b1;

  dual_wheel_torque_pid_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_target_left(in_target_left),
    .in_target_right(in_target_right),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_torque_left(out_torque_left),
    .out_torque_right(out_torque_right),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic signed [DATA_W-1:0] clip32(input longint x);
    if (x > longint'(Q_MAX)) return Q_MAX;
    if (x < longint'(Q_MIN)) return Q_MIN;
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] advance_wheel(input int w,
                                                            input logic signed [DATA_W-1:0] target);
    longint e, de, t, p, lim;
    p = longint'(period);
    lim = longint'(limit);
    e = clip32(longint'(target) - longint'(applied[w]));
    de = 0;
    if (p > 0) begin
      de = clip32(((e - longint'(last_err[w])) * (1 <<< FRAC_W)) / p);
      integ[w] = clip32(longint'(integ[w]) + ((p * e) >>> FRAC_W));
    end
    t = longint'(applied[w])
        + ((longint'(kp) * e) >>> FRAC_W)
        + ((longint'(kd) * de) >>> FRAC_W)
        + ((longint'(ki) * longint'(integ[w])) >>> FRAC_W);
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    applied[w] = t[DATA_W-1:0];
    last_err[w] = e[DATA_W-1:0];
    return t[DATA_W-1:0];
  endfunction

  function automatic torque_pair_t predict_torques(input logic signed [DATA_W-1:0] left,
                                                   input logic signed [DATA_W-1:0] right);
    torque_pair_t res;
    logic signed [DATA_W-1:0] tgt [2];
    logic signed [DATA_W-1:0] got [2];
    tgt[0] = left;
    tgt[1] = right;
    got[0] = '0;
    got[1] = '0;
    for (int w = 0; w < ACT_WHEELS; w++) got[w] = advance_wheel(w, tgt[w]);
    res.left = got[0];
    res.right = got[1];
    return res;
  endfunction

  function automatic void init_model();
    for (int w = 0; w < NUM_WHEELS; w++) begin
      applied[w] = '0;
      last_err[w] = '0;
      integ[w] = '0;
    end
    kp = GAIN_P_RST;
    ki = GAIN_I_RST;
    kd = GAIN_D_RST;
    period = PER_RST;
    limit = LIMIT_RST;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_target();
    int v;
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2, 3: return $urandom;
      default: begin
        v = $urandom_range(0, 8 * 65536);
        return v - 4 * 65536;
      end
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return GAIN_W'($urandom_range(0, 4 * 65536));
      4: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [PER_W-1:0] pick_period();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return PER_W'(1);
      2: return PER_W'(1048576);
      3: return PER_W'($urandom_range(0, 1048576));
      default: return PER_W'($urandom_range(1000, 20000));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(65536, 64 * 65536));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GAIN_P: kp = val[GAIN_W-1:0];
      CFG_GAIN_I: ki = val[GAIN_W-1:0];
      CFG_GAIN_D: kd = val[GAIN_W-1:0];
      CFG_STEP_PERIOD: period = val[PER_W-1:0];
      CFG_TORQUE_LIMIT: limit = val[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_targets(input logic signed [DATA_W-1:0] left,
                              input logic signed [DATA_W-1:0] right);
    int gap;
    gap = tx_gap_en ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_left <= left;
    in_target_right <= right;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    torque_q.push_back(predict_torques(left, right));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (torque_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_defaults();
    send_targets('0, '0);
    send_targets(Q_MAX, Q_MIN);
    send_targets(Q_MIN, Q_MAX);
    send_targets(32'sd32768, -32'sd98304);
    drain_results();
  endtask

  task automatic test_unused_index();
    for (int k = CFG_TORQUE_LIMIT + 1; k < 2 ** CFG_IDX_W; k++) begin
      write_reg(CFG_IDX_W'(k), '1);
    end
    send_targets(32'sd65536, -32'sd65536);
    send_targets(-32'sd131072, 32'sd200000);
    drain_results();
  endtask

  task automatic test_saturation();
    write_reg(CFG_GAIN_P, 65536);
    write_reg(CFG_GAIN_D, 65536);
    write_reg(CFG_GAIN_I, 1);
    write_reg(CFG_STEP_PERIOD, 1);
    write_reg(CFG_TORQUE_LIMIT, '1);
    // large error swings overflow the error and the derivative
    send_targets(Q_MAX, Q_MIN);
    send_targets(Q_MIN, Q_MAX);
    send_targets(Q_MAX, Q_MIN);
    send_targets(Q_MIN, Q_MIN);
    drain_results();
    write_reg(CFG_STEP_PERIOD, 1048576);
    write_reg(CFG_GAIN_I, '1);
    // long period drives the integral to its rail
    for (int n = 0; n < 4; n++) send_targets(Q_MIN, Q_MAX);
    drain_results();
  endtask

  task automatic test_zero_period();
    write_reg(CFG_STEP_PERIOD, '0);
    write_reg(CFG_GAIN_P, 32768);
    write_reg(CFG_GAIN_D, 3 * 65536);
    write_reg(CFG_GAIN_I, 2 * 65536);
    for (int n = 0; n < 3; n++) send_targets(pick_target(), pick_target());
    drain_results();
  endtask

  task automatic test_gain_extremes();
    write_reg(CFG_STEP_PERIOD, CFG_DATA_W'(PER_RST));
    write_reg(CFG_GAIN_P, '1);
    write_reg(CFG_GAIN_D, '1);
    write_reg(CFG_GAIN_I, '1);
    write_reg(CFG_TORQUE_LIMIT, '0);
    send_targets(Q_MAX, Q_MIN);
    send_targets(32'sd1000, -32'sd1000);
    drain_results();
    write_reg(CFG_TORQUE_LIMIT, '1);
    send_targets(Q_MAX, Q_MIN);
    send_targets(-32'sd1, 32'sd1);
    drain_results();
    write_reg(CFG_GAIN_P, '0);
    write_reg(CFG_GAIN_D, '0);
    write_reg(CFG_GAIN_I, '0);
    send_targets(Q_MIN, Q_MAX);
    drain_results();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_GAIN_P, 65536);
    write_reg(CFG_GAIN_I, 4096);
    write_reg(CFG_GAIN_D, 2048);
    write_reg(CFG_TORQUE_LIMIT, 16 * 65536);
    tx_gap_en = 1'b0;
    rx_hold = 400;
    for (int n = 0; n < 8; n++) send_targets(pick_target(), pick_target());
    drain_results();
    tx_gap_en = 1'b1;
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_GAIN_P, pick_gain());
      write_reg(CFG_GAIN_I, pick_gain());
      write_reg(CFG_GAIN_D, pick_gain());
      write_reg(CFG_STEP_PERIOD, CFG_DATA_W'(pick_period()));
      write_reg(CFG_TORQUE_LIMIT, pick_limit());
      tx_gap_en = (ph % 3 != 2);
      rx_stall_en = (ph % 3 != 2);
      for (int n = 0; n < 60; n++) send_targets(pick_target(), pick_target());
      drain_results();
    end
    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  initial begin : rx_side
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall = stall - 1;
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall = pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : torque_check
    torque_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (torque_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual left %0d right %0d",
                 $time, out_torque_left, out_torque_right);
        mismatch_cnt++;
      end else begin
        want = torque_q.pop_front();
        if (out_torque_left !== want.left) begin
          $display("%0t: torque_left expected %0d actual %0d",
                   $time, want.left, out_torque_left);
          mismatch_cnt++;
        end
        if (out_torque_right !== want.right) begin
          $display("%0t: torque_right expected %0d actual %0d",
                   $time, want.right, out_torque_right);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_target_left = '0;
    in_target_right = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    init_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_unused_index();
    test_saturation();
    test_zero_period();
    test_gain_extremes();
    test_backpressure();
    test_random();
    drain_results();
    repeat (200) @(posedge clk);
    if (torque_q.size() != 0) begin
      $display("%0t: %0d items still expected, actual none", $time, torque_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dwtp_pkg.sv
hw/rtl/dwtp_div.sv
hw/rtl/dwtp_mul.sv
hw/rtl/dual_wheel_torque_pid_top.sv
sim/tb_dual_wheel_torque_pid_top.sv
